FILE: hdl/assert_macros.svh
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: hdl/bpa_pkg.sv
// Package for the buddy page allocator: constants, codes and queue entry type.
package bpa_pkg;
   localparam int MaxOrderDef  = 8;
   localparam int PageBytesDef = 4096;
   localparam int PagesDef     = 256;

   localparam logic [3:0] MARK_INNER = 4'd13;
   localparam logic [3:0] MARK_USED  = 4'd14;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TOO_BIG = 3'd1;
   localparam logic [2:0] ST_NO_FREE = 3'd2;
   localparam logic [2:0] ST_BAD_IDX = 3'd3;
   localparam logic [2:0] ST_LOST    = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // classified request handed from front to back
   typedef struct packed {
      logic       op;
      logic       too_big;
      logic       bad_idx;
      logic [3:0] want;
      logic [8:0] idx;
   } cmd_type;
endpackage

FILE: hdl/bpa_ram.sv
// Generic single-port RAM with registered read.
module bpa_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: hdl/bpa_front.sv
// Front end: size to order, free index range check, two-entry request queue.
module bpa_front #(
   parameter int MaxOrder  = bpa_pkg::MaxOrderDef,
   parameter int PageBytes = bpa_pkg::PageBytesDef,
   parameter int Pages     = bpa_pkg::PagesDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [31:0]      req_size_bytes,
   input  logic [8:0]       req_page_index,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output bpa_pkg::cmd_type cmd
);
   import bpa_pkg::*;

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   cmd_type    c_in;
   logic [4:0] w;
   logic       acc;

   // smallest order whose byte span covers the request; MaxOrder+1 means too big
   always_comb begin
      w = 5'(MaxOrder + 1);
      for (int k = MaxOrder; k >= 0; k--) begin
         if ({32'd0, req_size_bytes} <= (64'(PageBytes) << k)) begin
            w = 5'(k);
         end
      end
      c_in.op      = req_op;
      c_in.too_big = (w > 5'(MaxOrder));
      c_in.want    = w[3:0];
      c_in.idx     = req_page_index;
      c_in.bad_idx = ({23'd0, req_page_index} >= 32'(Pages));
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign acc       = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign cnt_in    = cnt_ff + {1'b0, acc} - {1'b0, cmd_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (acc) begin
            wr_ff <= !wr_ff;
         end
         if (cmd_take) begin
            rd_ff <= !rd_ff;
         end
      end
      if (acc) begin
         q_ff[wr_ff] <= c_in;
      end
   end
endmodule

FILE: hdl/bpa_back.sv
// Back end: sequencer over the mark, order and link memories and the list heads.
module bpa_back #(
   parameter int MaxOrder = bpa_pkg::MaxOrderDef,
   parameter int Pages    = bpa_pkg::PagesDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  bpa_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_block_page,
   output logic [3:0]       rsp_block_order,
   output logic             busy
);
   import bpa_pkg::*;

   localparam int AW = $clog2(Pages);
   localparam int HW = AW + 1;           // head/link width, all ones means null
   localparam int NH = MaxOrder + 1;
   localparam logic [HW-1:0] NIL = '1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ASCAN, S_APOP, S_APOPW, S_SPLIT, S_SMARK, S_UMARK,
      S_FRD, S_FCHK, S_BSCAN, S_BSCANW, S_WALK, S_WALKW, S_UNLINK,
      S_PUSH, S_FMARK, S_DONE
   } state_type;

   state_type   state_ff;
   logic [HW-1:0] head_ff [NH];
   logic [AW:0]   ptr_ff;             // general page counter, AW+1 to hold Pages
   logic [AW:0]   cnt_ff;             // span counter / walk steps
   logic [3:0]    want_ff, ord_ff;
   logic [AW-1:0] blk_ff, idx_ff, bud_ff;
   logic [HW-1:0] prev_ff, cur_ff;
   logic [2:0]    st_ff;
   logic          out_v_ff;
   logic [7:0]    out_p_ff;
   logic [3:0]    out_o_ff;

   // memory ports
   logic          mk_we, ho_we, lk_we;
   logic [AW-1:0] mk_a, ho_a, lk_a;
   logic [3:0]    mk_wd, mk_rd, ho_wd, ho_rd;
   logic [HW-1:0] lk_wd, lk_rd;

   bpa_ram #(.Width(4), .Depth(Pages)) u_mark (
      .clock(clock), .wr_en(mk_we), .addr(mk_a), .wr_data(mk_wd), .rd_data(mk_rd));
   bpa_ram #(.Width(4), .Depth(Pages)) u_hord (
      .clock(clock), .wr_en(ho_we), .addr(ho_a), .wr_data(ho_wd), .rd_data(ho_rd));
   bpa_ram #(.Width(HW), .Depth(Pages)) u_link (
      .clock(clock), .wr_en(lk_we), .addr(lk_a), .wr_data(lk_wd), .rd_data(lk_rd));

   logic [AW:0] span;
   assign span = (AW+1)'(1) << ord_ff;

   // memory access decode per state
   always_comb begin
      mk_we = 1'b0; ho_we = 1'b0; lk_we = 1'b0;
      mk_a = ptr_ff[AW-1:0]; ho_a = ptr_ff[AW-1:0]; lk_a = ptr_ff[AW-1:0];
      mk_wd = MARK_INNER; ho_wd = '0; lk_wd = NIL;
      case (state_ff)
         S_CLEAR: begin
            mk_we = 1'b1; ho_we = 1'b1; lk_we = 1'b1;
            mk_wd = (ptr_ff == '0) ? 4'(MaxOrder) : MARK_INNER;
            ho_wd = (ptr_ff == '0) ? 4'(MaxOrder) : 4'd0;
         end
         S_APOP:  lk_a = blk_ff;
         S_APOPW: begin lk_a = blk_ff; lk_we = 1'b1; end
         S_SPLIT: begin
            // push upper half of order ord_ff-1
            lk_a = ptr_ff[AW-1:0]; lk_we = 1'b1;
            lk_wd = head_ff[ord_ff - 4'd1];
            ho_a = ptr_ff[AW-1:0]; ho_we = 1'b1; ho_wd = ord_ff - 4'd1;
         end
         S_SMARK: begin
            mk_a = ptr_ff[AW-1:0]; mk_we = 1'b1;
            mk_wd = (cnt_ff == '0) ? ord_ff : MARK_INNER;
         end
         S_UMARK: begin
            mk_a = ptr_ff[AW-1:0]; mk_we = 1'b1; mk_wd = MARK_USED;
            ho_a = blk_ff; ho_we = (cnt_ff == '0); ho_wd = want_ff;
         end
         S_FRD: begin mk_a = idx_ff; ho_a = idx_ff; end
         S_BSCAN: mk_a = ptr_ff[AW-1:0];
         S_WALK: lk_a = cur_ff[AW-1:0];
         S_UNLINK: begin
            lk_a = prev_ff[AW-1:0]; lk_we = (prev_ff != NIL); lk_wd = lk_rd;
         end
         S_PUSH: begin
            lk_a = idx_ff; lk_we = 1'b1; lk_wd = head_ff[ord_ff];
            ho_a = idx_ff; ho_we = 1'b1; ho_wd = ord_ff;
         end
         S_FMARK: begin
            mk_a = ptr_ff[AW-1:0]; mk_we = 1'b1;
            mk_wd = (cnt_ff == '0) ? ord_ff : MARK_INNER;
         end
         default: ;
      endcase
   end

   assign cmd_take        = (state_ff == S_IDLE) && cmd_valid && !out_v_ff;
   assign rsp_valid       = out_v_ff;
   assign rsp_status      = st_ff;
   assign rsp_block_page  = out_p_ff;
   assign rsp_block_order = out_o_ff;
   assign busy            = (state_ff != S_IDLE);

   logic [AW-1:0] bud_c;
   assign bud_c = idx_ff ^ AW'((AW+1)'(1) << ord_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < NH; i++) begin
            head_ff[i] <= (i == MaxOrder) ? HW'(0) : NIL;
         end
      end else begin
         if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == (AW+1)'(Pages - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_take) begin
                  want_ff <= cmd.want;
                  idx_ff  <= cmd.idx[AW-1:0];
                  ord_ff  <= cmd.want;
                  out_p_ff <= '0; out_o_ff <= '0;
                  if (cmd.op == OP_ALLOC) begin
                     if (cmd.too_big) begin
                        st_ff <= ST_TOO_BIG; state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_ASCAN;
                     end
                  end else if (cmd.bad_idx) begin
                     st_ff <= ST_BAD_IDX; state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_FRD;
                  end
               end
            end
            // search upward for a non-empty list
            S_ASCAN: begin
               if (head_ff[ord_ff] != NIL) begin
                  blk_ff   <= head_ff[ord_ff][AW-1:0];
                  state_ff <= S_APOP;
               end else if (ord_ff == 4'(MaxOrder)) begin
                  st_ff <= ST_NO_FREE; state_ff <= S_DONE;
               end else begin
                  ord_ff <= ord_ff + 4'd1;
               end
            end
            S_APOP: state_ff <= S_APOPW;
            S_APOPW: begin
               head_ff[ord_ff] <= lk_rd;
               state_ff <= (ord_ff > want_ff) ? S_SPLIT : S_UMARK;
               cnt_ff <= '0;
               if (ord_ff == want_ff) begin
                  ptr_ff <= (AW+1)'(blk_ff);
               end else begin
                  ptr_ff <= (AW+1)'(blk_ff) + (span >> 1);
               end
            end
            S_SPLIT: begin
               head_ff[ord_ff - 4'd1] <= (HW)'(ptr_ff);
               ord_ff   <= ord_ff - 4'd1;
               cnt_ff   <= '0;
               state_ff <= S_SMARK;
            end
            S_SMARK: begin
               if (cnt_ff == span - 1'b1) begin
                  cnt_ff <= '0;
                  if (ord_ff > want_ff) begin
                     ptr_ff   <= (AW+1)'(blk_ff) + (span >> 1);
                     state_ff <= S_SPLIT;
                  end else begin
                     ptr_ff   <= (AW+1)'(blk_ff);
                     state_ff <= S_UMARK;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_UMARK: begin
               if (cnt_ff == span - 1'b1) begin
                  st_ff <= ST_OK; out_p_ff <= 8'(blk_ff); out_o_ff <= want_ff;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_FRD: state_ff <= S_FCHK;
            S_FCHK: begin
               if (mk_rd != MARK_USED || ho_rd > 4'(MaxOrder) ||
                   ((AW+1)'(idx_ff) & (((AW+1)'(1) << ho_rd) - 1'b1)) != '0) begin
                  st_ff <= ST_BAD_IDX; state_ff <= S_DONE;
               end else begin
                  ord_ff <= ho_rd;
                  state_ff <= S_BSCAN;
                  ptr_ff <= '0; cnt_ff <= '0;
               end
            end
            // check buddy region for used pages
            S_BSCAN: begin
               if (ord_ff >= 4'(MaxOrder)) begin
                  state_ff <= S_PUSH;
               end else begin
                  bud_ff <= bud_c;
                  if ((AW+1)'(bud_c) + span > (AW+1)'(Pages) ||
                      32'(bud_c) + 32'(span) > 32'(Pages)) begin
                     state_ff <= S_PUSH;
                  end else begin
                     ptr_ff <= (AW+1)'(bud_c);
                     cnt_ff <= '0;
                     state_ff <= S_BSCANW;
                  end
               end
            end
            S_BSCANW: begin
               // mk_a = ptr_ff issued last cycle in S_BSCANW entry; pipeline read
               if (cnt_ff != '0 && mk_rd == MARK_USED) begin
                  state_ff <= S_PUSH;
               end else if (cnt_ff == span) begin
                  cur_ff <= head_ff[ord_ff]; prev_ff <= NIL; cnt_ff <= '0;
                  state_ff <= S_WALK;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_WALK: begin
               if (cur_ff >= HW'(Pages) || cnt_ff == (AW+1)'(Pages)) begin
                  st_ff <= ST_LOST; out_p_ff <= 8'(idx_ff); out_o_ff <= ord_ff;
                  state_ff <= S_DONE;
               end else if (cur_ff[AW-1:0] == bud_ff) begin
                  state_ff <= S_UNLINK;
               end else begin
                  state_ff <= S_WALKW;
               end
            end
            S_WALKW: begin
               prev_ff <= cur_ff; cur_ff <= lk_rd; cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_WALK;
            end
            S_UNLINK: begin
               if (prev_ff == NIL) begin
                  head_ff[ord_ff] <= lk_rd;
               end
               if (bud_ff < idx_ff) begin
                  idx_ff <= bud_ff;
               end
               ord_ff <= ord_ff + 4'd1;
               state_ff <= S_BSCAN;
            end
            S_PUSH: begin
               head_ff[ord_ff] <= HW'(idx_ff);
               ptr_ff <= (AW+1)'(idx_ff); cnt_ff <= '0;
               state_ff <= S_FMARK;
            end
            S_FMARK: begin
               if (cnt_ff == span - 1'b1) begin
                  st_ff <= ST_OK; out_p_ff <= 8'(idx_ff); out_o_ff <= ord_ff;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_DONE: begin
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: hdl/buddy_page_allocator_core.sv
// Buddy page allocator: front classifier, request queue and back sequencer.
// An allocate searches upward past empty lists, splits the block it finds down to the
// wanted order, pushing and marking each upper half, then marks its pages used; a free
// checks the page, merges with each free buddy it finds and unlinks, then marks the block.
// One request at a time in the back end; the front queues two more.
// Reset (synchronous) starts a clearing pass over the memories.
`include "assert_macros.svh"
module buddy_page_allocator_core #(
   parameter int MaxOrder  = bpa_pkg::MaxOrderDef,
   parameter int PageBytes = bpa_pkg::PageBytesDef,
   parameter int Pages     = bpa_pkg::PagesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_size_bytes,
   input  logic [8:0]  req_page_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_block_page,
   output logic [3:0]  rsp_block_order
);
   import bpa_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_take, busy;

   // front: works out the order and range flags on each request
   bpa_front #(.MaxOrder(MaxOrder), .PageBytes(PageBytes), .Pages(Pages)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_size_bytes(req_size_bytes),
      .req_page_index(req_page_index), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd));

   // back: walks lists and page marks
   bpa_back #(.MaxOrder(MaxOrder), .Pages(Pages)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_block_page(rsp_block_page),
      .rsp_block_order(rsp_block_order), .busy(busy));

   // a request is only taken by an idle back end
   `ASSERT_IMPLIES(a_take_idle, clock, reset, cmd_take, !busy && cmd_valid)
   // a stalled response holds its status
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))
   // status is always a defined code
   `ASSERT_IMPLIES(a_status_rng, clock, reset, rsp_valid, rsp_status <= ST_LOST)
endmodule

FILE: tb/sv/tb_buddy_page_allocator_core.sv
// Testbench for the buddy page allocator core: directed and random requests checked against a model.
module tb_buddy_page_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int MaxOrd   = 8;
   localparam int NumPages = 256;
   localparam int PgBytes  = 4096;
   localparam int Nil      = 16'hFFFF;
   localparam int CycleLimit = 5_000_000;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] page;
      logic [3:0] order;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_ALLOC;
   logic [31:0] req_size_bytes = '0;
   logic [8:0]  req_page_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_block_page;
   logic [3:0]  rsp_block_order;

   buddy_page_allocator_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the allocator state
   logic [3:0]  mark_q [NumPages];
   logic [3:0]  hdr_q  [NumPages];
   int unsigned link_q [NumPages];
   int unsigned head_q [MaxOrd+1];

   alloc_result_type expected_results[$];
   int unsigned   live_blocks[$];     // pages of blocks currently held
   int            error_count = 0;
   int unsigned   cycle_count = 0;
   bit            hold_off = 1'b0;    // long receiver stall in progress
   bit            rsp_idle_on = 1'b1;
   bit            req_idle_on = 1'b1;
   int            rsp_wait = 0;       // receiver wait cycles left for this response

   function automatic void model_reset();
      for (int i = 0; i < NumPages; i++) begin
         mark_q[i] = MARK_INNER;
         hdr_q[i]  = '0;
         link_q[i] = Nil;
      end
      for (int i = 0; i <= MaxOrd; i++) head_q[i] = Nil;
      mark_q[0] = 4'(MaxOrd);
      hdr_q[0]  = 4'(MaxOrd);
      head_q[MaxOrd] = 0;
   endfunction

   function automatic void mark_free(int unsigned start, int unsigned ord);
      for (int unsigned i = 0; i < (1 << ord); i++)
         if (start + i < NumPages) mark_q[start+i] = (i == 0) ? 4'(ord) : MARK_INNER;
   endfunction

   function automatic void push_free(int unsigned start, int unsigned ord);
      if (start >= NumPages) return;
      link_q[start] = head_q[ord];
      head_q[ord]   = start;
      hdr_q[start]  = 4'(ord);
   endfunction

   function automatic bit span_free(int unsigned start, int unsigned ord);
      for (int unsigned i = 0; i < (1 << ord); i++)
         if (start + i >= NumPages || mark_q[start+i] == MARK_USED) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit unlink_free(int unsigned target, int unsigned ord);
      int unsigned prev, cur, steps;
      prev = Nil;
      cur = head_q[ord];
      steps = 0;
      while (cur < NumPages && steps < NumPages) begin
         if (cur == target) begin
            if (prev == Nil) head_q[ord] = link_q[cur];
            else link_q[prev] = link_q[cur];
            return 1'b1;
         end
         prev = cur;
         cur = link_q[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   // works out the response to one request and updates the shadow state
   function automatic alloc_result_type predict_request(logic op, logic [31:0] size,
                                                        logic [8:0] index);
      alloc_result_type r;
      int unsigned want, have, blk, idx, ord, bud;
      bit lost;
      r = '0;
      if (op == OP_ALLOC) begin
         want = 0;
         while (want <= MaxOrd && 64'(size) > (64'(PgBytes) << want)) want++;
         if (want > MaxOrd) r.status = ST_TOO_BIG;
         else begin
            have = want;
            while (have <= MaxOrd && head_q[have] >= NumPages) have++;
            if (have > MaxOrd) r.status = ST_NO_FREE;
            else begin
               blk = head_q[have];
               head_q[have] = link_q[blk];
               link_q[blk] = Nil;
               for (int unsigned k = have; k > want; k--) begin
                  push_free(blk + (1 << (k-1)), k-1);
                  mark_free(blk + (1 << (k-1)), k-1);
               end
               hdr_q[blk] = 4'(want);
               for (int unsigned k = 0; k < (1 << want); k++)
                  if (blk + k < NumPages) mark_q[blk+k] = MARK_USED;
               r.status = ST_OK;
               r.page = 8'(blk);
               r.order = 4'(want);
               live_blocks.push_back(blk);
            end
         end
      end else begin
         idx = index;
         if (idx >= NumPages || mark_q[idx] != MARK_USED || hdr_q[idx] > MaxOrd ||
             (idx & ((1 << hdr_q[idx]) - 1)) != 0) begin
            r.status = ST_BAD_IDX;
         end else begin
            lost = 1'b0;
            ord = hdr_q[idx];
            while (ord < MaxOrd) begin
               bud = idx ^ (1 << ord);
               if (!span_free(bud, ord)) break;
               if (!unlink_free(bud, ord)) begin
                  lost = 1'b1;
                  break;
               end
               if (bud < idx) idx = bud;
               ord++;
            end
            if (lost) r.status = ST_LOST;
            else begin
               push_free(idx, ord);
               mark_free(idx, ord);
               r.status = ST_OK;
            end
            r.page = 8'(idx);
            r.order = 4'(ord);
            foreach (live_blocks[i])
               if (live_blocks[i] == index) begin
                  live_blocks.delete(i);
                  break;
               end
         end
      end
      return r;
   endfunction

   // offers one request, waits for acceptance, records the prediction;
   // valid stays up until the next gap or drain so back-to-back requests get one drive
   task automatic send_request(logic op, logic [31:0] size, logic [8:0] index);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_size_bytes <= size;
      req_page_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_request(op, size, index));
      @(negedge clock);
   endtask

   task automatic alloc_pages(logic [31:0] size);
      send_request(OP_ALLOC, size, 9'($urandom));
   endtask

   task automatic free_page(logic [8:0] index);
      send_request(OP_FREE, $urandom, index);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // size that maps to a given order, anywhere inside that order's range
   function automatic logic [31:0] size_for_order(int unsigned ord);
      if (ord == 0) return $urandom_range(0, PgBytes);
      return $urandom_range((PgBytes << (ord-1)) + 1, PgBytes << ord);
   endfunction

   // receiver: waits a drawn number of cycles per response, or a long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end
      else rsp_stall <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_wait = rsp_idle_on ? $urandom_range(0, 13) : 0;
         if (expected_results.size() == 0) begin
            $error("unexpected response status=%0d page=%0d order=%0d",
                   rsp_status, rsp_block_page, rsp_block_order);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_block_page !== exp_r.page) begin
               $error("block_page: expected %0d, got %0d", exp_r.page, rsp_block_page);
               error_count++;
            end
            if (rsp_block_order !== exp_r.order) begin
               $error("block_order: expected %0d, got %0d", exp_r.order, rsp_block_order);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // extremes of size, zero size, too large, no free block, bad indices
   task automatic test_directed();
      alloc_pages(32'd0);                  // zero size gives order 0
      alloc_pages(32'd1);
      alloc_pages(32'd4096);
      alloc_pages(32'd4097);
      alloc_pages(32'hFFFF_FFFF);          // too large
      alloc_pages(32'd1048577);            // just over the top order
      free_page(9'd511);                   // beyond the page count
      free_page(9'd256);
      free_page(9'd200);                   // not allocated
      free_page(9'd3);                     // a free order-0 page, not allocated
      free_page(9'd0);
      free_page(9'd1);
      free_page(9'd2);                     // merges back up
      free_page(9'd0);                     // double free
      alloc_pages(32'd1048576);            // whole memory, while an order-1 block is still held
      alloc_pages(32'd1);                  // one page, served from the free lists
      free_page(9'd0);
      free_page(9'd255);
      drain();
   endtask

   // fill and empty by allocation patterns, mostly well formed
   task automatic test_random(int unsigned n);
      int unsigned pick;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) alloc_pages(size_for_order($urandom_range(0, 3) == 0 ?
                                    $urandom_range(0, MaxOrd) : $urandom_range(0, 2)));
         else if (pick < 85 && live_blocks.size() != 0)
            free_page(9'(live_blocks[$urandom_range(0, live_blocks.size()-1)]));
         else if (pick < 92) alloc_pages($urandom);
         else free_page(9'($urandom));
      end
      drain();
   endtask

   // receiver holds off while requests keep coming, filling the queue
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            req_idle_on = 1'b0;
            for (int i = 0; i < 12; i++) alloc_pages(size_for_order($urandom_range(0, 2)));
            req_idle_on = 1'b1;
         end
      join
      drain();
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(480);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: buddy_page_allocator_core.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_front.sv
hdl/bpa_back.sv
hdl/buddy_page_allocator_core.sv
tb/sv/tb_buddy_page_allocator_core.sv
